>>> rtl/core/stencil_average_star_counter_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the star counter core
// Wraps concurrent assertions so that synthesis sees nothing of them.
// ----------------------------------------------------------------------------
`ifndef STENCIL_AVERAGE_STAR_COUNTER_CORE_MACROS_SVH
`define STENCIL_AVERAGE_STAR_COUNTER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off while rst_n is low
`define SASC_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, sampled on clk, off while rst_n is low
`define SASC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SASC_ASSERT_IMPLIES(label, ante, cons, msg)
`define SASC_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

>>> rtl/core/sasc_pkg.sv
// ----------------------------------------------------------------------------
// Star counter package
// Sizes, types and register codes shared by the star counter core.
// ----------------------------------------------------------------------------
`default_nettype none

package sasc_pkg;

  // Image geometry and pixel depth
  localparam int MAX_COLUMNS    = 1024;
  localparam int PIXEL_BITS     = 8;
  localparam int ROW_LIMIT      = 1024;
  localparam int COL_BITS       = $clog2(MAX_COLUMNS);
  localparam int ROW_BITS       = $clog2(ROW_LIMIT);

  // Word and register widths
  localparam int IN_PIXEL_BITS  = 8;
  localparam int COUNT_BITS     = 20;
  localparam int SIZE_BITS      = 11;
  localparam int THR_BITS       = 8;
  localparam int CFG_DATA_BITS  = 11;
  localparam int CFG_INDEX_BITS = 2;

  // Five-point sum and its threshold limit
  localparam int STENCIL_POINTS = 5;
  localparam int SUM_BITS       = PIXEL_BITS + 3;
  localparam int LIM_BITS       = THR_BITS + 3;
  localparam int CMP_BITS       = (SUM_BITS > LIM_BITS) ? SUM_BITS : LIM_BITS;

  // Register reset values
  localparam int DEFAULT_COLS   = 640;
  localparam int DEFAULT_ROWS   = 480;
  localparam int DEFAULT_THR    = 6;

  // Result queue
  localparam int FIFO_DEPTH     = 4;
  localparam int FIFO_PTR_BITS  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_BITS  = FIFO_PTR_BITS + 1;

  typedef logic [PIXEL_BITS-1:0]    pix_t;
  typedef logic [IN_PIXEL_BITS-1:0] in_pix_t;
  typedef logic [COL_BITS-1:0]      col_t;
  typedef logic [ROW_BITS-1:0]      row_t;
  typedef logic [SUM_BITS-1:0]      sum_t;
  typedef logic [LIM_BITS-1:0]      lim_t;
  typedef logic [COUNT_BITS-1:0]    count_t;
  typedef logic [FIFO_CNT_BITS-1:0] fill_t;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_COLUMNS   = 2'd0,
    CFG_ROWS      = 2'd1,
    CFG_THRESHOLD = 2'd2
  } cfg_index_t;

  // Access control for one line store cell
  typedef struct packed {
    logic acc;
    col_t col;
    col_t col_ahead;
  } line_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/core/sasc_pixel_if.sv
// ----------------------------------------------------------------------------
// Pixel channel
// Valid/ready channel carrying one raster pixel per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface sasc_pixel_if;
  import sasc_pkg::*;

  logic    valid;
  logic    ready;
  in_pix_t pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

`default_nettype wire

>>> rtl/core/sasc_count_if.sv
// ----------------------------------------------------------------------------
// Count channel
// Valid/ready channel carrying one frame's star count per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface sasc_count_if;
  import sasc_pkg::*;

  logic   valid;
  logic   ready;
  count_t star_count;

  modport source (output valid, output star_count, input ready);
  modport sink   (input valid, input star_count, output ready);
endinterface

`default_nettype wire

>>> rtl/core/sasc_line_cell.sv
// ----------------------------------------------------------------------------
// Line store cell
// One row of pixels. Reads the column and its right neighbour when a word is
// taken, and writes the incoming value at that column on the following cycle.
// The old value read out feeds the next cell of the chain.
// ----------------------------------------------------------------------------
`default_nettype none

module sasc_line_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sasc_pkg::line_ctrl_t ctrl,
  input  sasc_pkg::pix_t       wr_data,
  output sasc_pkg::pix_t       rd_data,
  output sasc_pkg::pix_t       rd_ahead
);
  import sasc_pkg::*;

  pix_t store_r [MAX_COLUMNS];
  pix_t rd_data_r;
  pix_t rd_ahead_r;
  logic wr_pend_r;
  col_t wr_col_r;

  // Arm the write for the cycle after a word is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_pend_r <= 1'b0;
    end else begin
      wr_pend_r <= ctrl.acc;
    end
  end

  // Read old contents first, then write the delayed value
  always_ff @(posedge clk) begin
    if (ctrl.acc) begin
      wr_col_r   <= ctrl.col;
      rd_data_r  <= store_r[ctrl.col];
      rd_ahead_r <= store_r[ctrl.col_ahead];
    end
    if (wr_pend_r) begin
      store_r[wr_col_r] <= wr_data;
    end
  end

  assign rd_data  = rd_data_r;
  assign rd_ahead = rd_ahead_r;

endmodule

`default_nettype wire

>>> rtl/core/sasc_result_fifo.sv
// ----------------------------------------------------------------------------
// Result queue
// Small register queue that holds frame counts until the receiver takes them.
// ----------------------------------------------------------------------------
`default_nettype none
`include "stencil_average_star_counter_core_macros.svh"

module sasc_result_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  sasc_pkg::count_t push_data,
  output sasc_pkg::fill_t  fill,
  sasc_count_if.source     out_ch
);
  import sasc_pkg::*;

  count_t                   slot_r [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  fill_t                    fill_r, fill_nxt;
  logic                     pop;

  // Drive the head word
  assign out_ch.valid      = (fill_r != '0);
  assign out_ch.star_count = slot_r[rd_ptr_r];
  assign pop               = out_ch.valid && out_ch.ready;
  assign fill              = fill_r;

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_nxt = push ? FIFO_PTR_BITS'(wr_ptr_r + FIFO_PTR_BITS'(1)) : wr_ptr_r;
    rd_ptr_nxt = pop ? FIFO_PTR_BITS'(rd_ptr_r + FIFO_PTR_BITS'(1)) : rd_ptr_r;
    fill_nxt   = fill_t'(fill_r + fill_t'(push) - fill_t'(pop));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Store the pushed word
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  `SASC_ASSERT_IMPLIES(a_no_overflow, push && !pop, fill_r < fill_t'(FIFO_DEPTH), "result queue overflow")
  `SASC_ASSERT_IMPLIES(a_ptr_gap, 1'b1, FIFO_PTR_BITS'(wr_ptr_r - rd_ptr_r) == fill_r[FIFO_PTR_BITS-1:0], "queue pointers disagree with fill level")
  `SASC_ASSERT_NEXT(a_fill_push, push && !pop, fill_r == fill_t'($past(fill_r) + fill_t'(1)), "fill level did not rise on push")

endmodule

`default_nettype wire

>>> rtl/core/stencil_average_star_counter_core.sv
// ----------------------------------------------------------------------------
// Five-point stencil star counter
// Counts interior pixels of a raster frame whose plus-shaped mean exceeds a
// threshold, and reports the count once per frame.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one pixel per word, raster order, valid/ready.
//   out_ch : one star count per frame, valid/ready, sent with the frame's last
//            pixel; images under three rows or columns report zero.
//   cfg_*  : write enable, index and data; columns (0), rows (1) and mean
//            threshold (2). Write only while no pixel is in flight.
//   Throughput is one pixel per cycle while in_ch.ready is high. A frame's count
//   is registered through stage 1 (line store read), stage 2 (threshold
//   compare and count) and the result queue before it appears on out_ch.
//   Two line store cells in a chain hold the previous two rows; the first
//   passes each old pixel on to the second as the row moves past.
//   Counts wait in a four-word queue; in_ch.ready drops only when the counts
//   queued and in flight could fill it, so pixels keep flowing while the
//   receiver stalls until then.
//   Reset restores the register defaults (640 x 480, threshold 6) and clears
//   the counters and the running count. Line stores are not cleared: the
//   first two rows of every frame rewrite them before they are read.
// ----------------------------------------------------------------------------
`default_nettype none
`include "stencil_average_star_counter_core_macros.svh"

module stencil_average_star_counter_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [sasc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [sasc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  sasc_pixel_if.sink                          in_ch,
  sasc_count_if.source                        out_ch
);
  import sasc_pkg::*;

  // Last column index from a column register value
  function automatic col_t last_col(input logic [SIZE_BITS-1:0] v);
    if (v == '0) begin
      return '0;
    end else if (int'(v) > MAX_COLUMNS) begin
      return col_t'(MAX_COLUMNS - 1);
    end else begin
      return col_t'(v - SIZE_BITS'(1));
    end
  endfunction

  // Last row index from a row register value
  function automatic row_t last_row(input logic [SIZE_BITS-1:0] v);
    if (v == '0) begin
      return '0;
    end else if (int'(v) > ROW_LIMIT) begin
      return row_t'(ROW_LIMIT - 1);
    end else begin
      return row_t'(v - SIZE_BITS'(1));
    end
  endfunction

  // Smallest five-point sum whose truncated mean exceeds the threshold
  function automatic lim_t sum_limit(input logic [THR_BITS-1:0] t);
    return lim_t'((lim_t'(t) << 2) + lim_t'(t) + lim_t'(STENCIL_POINTS));
  endfunction

  cfg_index_t cfg_sel;
  col_t       cols_m1_r, cols_m1_nxt;
  row_t       rows_m1_r, rows_m1_nxt;
  lim_t       lim_r, lim_nxt;

  col_t       col_r, col_nxt;
  row_t       row_r, row_nxt;
  logic       accept;
  logic       col_end, row_end, centre_ok;

  logic       s1_valid_r, s1_eval_r, s1_last_r;
  pix_t       s1_pix_r;
  pix_t       left_r, left_nxt;
  pix_t       mid, right_px, up;
  sum_t       sum;

  logic       s2_valid_r, s2_hit_r, s2_last_r;
  count_t     cnt_r, cnt_nxt;
  count_t     cnt_fin;
  logic       push;

  fill_t      fifo_fill;
  fill_t      inflight;
  fill_t      committed;
  line_ctrl_t line_ctrl;

  // Decode configuration writes
  assign cfg_sel = cfg_index_t'(cfg_index);

  always_comb begin
    cols_m1_nxt = cols_m1_r;
    rows_m1_nxt = rows_m1_r;
    lim_nxt     = lim_r;
    if (cfg_we) begin
      unique case (cfg_sel)
        CFG_COLUMNS:   cols_m1_nxt = last_col(cfg_data);
        CFG_ROWS:      rows_m1_nxt = last_row(cfg_data);
        CFG_THRESHOLD: lim_nxt     = sum_limit(cfg_data[THR_BITS-1:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_m1_r <= last_col(SIZE_BITS'(DEFAULT_COLS));
      rows_m1_r <= last_row(SIZE_BITS'(DEFAULT_ROWS));
      lim_r     <= sum_limit(THR_BITS'(DEFAULT_THR));
    end else begin
      cols_m1_r <= cols_m1_nxt;
      rows_m1_r <= rows_m1_nxt;
      lim_r     <= lim_nxt;
    end
  end

  // Hold off input when queued and in-flight counts could fill the queue
  assign inflight  = fill_t'(s1_valid_r && s1_last_r) + fill_t'(s2_valid_r && s2_last_r);
  assign committed = fill_t'(fifo_fill + inflight);
  assign in_ch.ready = (committed < fill_t'(FIFO_DEPTH));
  assign accept      = in_ch.valid && in_ch.ready;

  // Raster position of the incoming pixel
  assign col_end   = (col_r >= cols_m1_r);
  assign row_end   = (row_r >= rows_m1_r);
  assign centre_ok = (cols_m1_r >= col_t'(2)) && (rows_m1_r >= row_t'(2)) &&
                     (row_r >= row_t'(2)) && (row_r <= rows_m1_r) &&
                     (col_r >= col_t'(1)) && (col_r < cols_m1_r);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (col_end) begin
        col_nxt = '0;
        row_nxt = row_end ? '0 : row_t'(row_r + row_t'(1));
      end else begin
        col_nxt = col_t'(col_r + col_t'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Line store chain: row above, then row two above
  assign line_ctrl.acc       = accept;
  assign line_ctrl.col       = col_r;
  assign line_ctrl.col_ahead = col_t'(col_r + col_t'(1));

  sasc_line_cell u_line_above (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (line_ctrl),
    .wr_data  (s1_pix_r),
    .rd_data  (mid),
    .rd_ahead (right_px)
  );

  sasc_line_cell u_line_two_above (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (line_ctrl),
    .wr_data  (mid),
    .rd_data  (up),
    .rd_ahead ()
  );

  // Stage 1: capture the pixel and its position flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r  <= pix_t'(in_ch.pixel);
      s1_eval_r <= centre_ok;
      s1_last_r <= col_end && row_end;
    end
  end

  // Left neighbour: previous centre value, cleared at frame end
  always_comb begin
    left_nxt = left_r;
    if (s1_valid_r) begin
      left_nxt = s1_last_r ? '0 : mid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
    end else begin
      left_r <= left_nxt;
    end
  end

  // Sum the plus-shaped neighbourhood
  assign sum = sum_t'(sum_t'(left_r) + sum_t'(mid) + sum_t'(right_px) +
                      sum_t'(up) + sum_t'(s1_pix_r));

  // Stage 2: compare against the threshold limit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      s2_hit_r  <= s1_eval_r && (CMP_BITS'(sum) >= CMP_BITS'(lim_r));
      s2_last_r <= s1_last_r;
    end
  end

  // Count hits, saturating; send and clear at frame end
  assign cnt_fin = (s2_hit_r && (cnt_r != '1)) ? count_t'(cnt_r + count_t'(1)) : cnt_r;
  assign push    = s2_valid_r && s2_last_r;

  always_comb begin
    cnt_nxt = cnt_r;
    if (s2_valid_r) begin
      cnt_nxt = s2_last_r ? '0 : cnt_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  sasc_result_fifo u_result_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (cnt_fin),
    .fill      (fifo_fill),
    .out_ch    (out_ch)
  );

  `SASC_ASSERT_IMPLIES(a_credit, 1'b1, committed <= fill_t'(FIFO_DEPTH), "queued and in-flight counts exceed queue depth")
  `SASC_ASSERT_NEXT(a_s1_follows, accept, s1_valid_r, "accepted pixel missing from stage 1")
  `SASC_ASSERT_NEXT(a_count_clear, push, cnt_r == '0, "running count not cleared after frame end")
  `SASC_ASSERT_NEXT(a_left_clear, s1_valid_r && s1_last_r, left_r == '0, "left neighbour not cleared after frame end")

endmodule

`default_nettype wire
